// ===== rtl/core/plf_pkg.sv =====
package plf_pkg;

   localparam int unsigned SqDim = 5;
   localparam int unsigned LetterBits = 5;

   typedef logic [LetterBits-1:0] letter_type;
   typedef logic [SqDim*LetterBits-1:0] row_type;
   typedef row_type square_type [SqDim];
   typedef logic [2:0] coord_type;
   typedef logic [2:0] reg_index_type;

   localparam letter_type CodeI = 5'd8;
   localparam letter_type CodeJ = 5'd9;
   localparam letter_type CodeX = 5'd23;

   // Where one letter was found in the square.
   typedef struct packed {
      logic      hit;
      coord_type row;
      coord_type col;
   } pos_type;

   function automatic letter_type fold(letter_type code);
      return (code == CodeJ) ? CodeI : code;
   endfunction

   // Step one place along a row or column, wrapping from the last to the first.
   function automatic coord_type wrap_inc(coord_type x);
      return (x == coord_type'(SqDim - 1)) ? '0 : coord_type'(x + 3'd1);
   endfunction

   function automatic letter_type cell_at(square_type sq, coord_type r, coord_type c);
      row_type rw;
      rw = '0;
      for (int i = 0; i < SqDim; i++) begin
         if (r == coord_type'(i)) begin
            rw = sq[i];
         end
      end
      return rw[LetterBits*c +: LetterBits];
   endfunction

endpackage

// ===== rtl/core/plf_req_if.sv =====
interface plf_req_if;
   logic                valid;
   logic                ready;
   plf_pkg::letter_type first_letter;
   plf_pkg::letter_type second_letter;
   logic                second_present;

   modport source (output valid, first_letter, second_letter, second_present, input ready);
   modport sink (input valid, first_letter, second_letter, second_present, output ready);
endinterface

// ===== rtl/core/plf_rsp_if.sv =====
interface plf_rsp_if;
   logic                valid;
   logic                ready;
   plf_pkg::letter_type cipher_first;
   plf_pkg::letter_type cipher_second;
   logic                letter_missing;

   modport source (output valid, cipher_first, cipher_second, letter_missing, input ready);
   modport sink (input valid, cipher_first, cipher_second, letter_missing, output ready);
endinterface

// ===== rtl/core/plf_csr_if.sv =====
interface plf_csr_if;
   logic                    valid;
   logic                    ready;
   plf_pkg::reg_index_type  index;
   plf_pkg::row_type        data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/plf_locate.sv =====
// One lane: finds a letter in the square and registers its position.
module plf_locate (
   input  logic                 clock,
   input  logic                 load,
   input  plf_pkg::square_type  square,
   input  plf_pkg::letter_type  letter,
   output plf_pkg::pos_type     pos_ff
);

   plf_pkg::pos_type pos_in;

   // Later cells overwrite earlier ones, so the last match in row order wins.
   always_comb begin
      pos_in = '0;
      for (int r = 0; r < plf_pkg::SqDim; r++) begin
         for (int c = 0; c < plf_pkg::SqDim; c++) begin
            if (square[r][plf_pkg::LetterBits*c +: plf_pkg::LetterBits] == letter) begin
               pos_in.hit = 1'b1;
               pos_in.row = plf_pkg::coord_type'(r);
               pos_in.col = plf_pkg::coord_type'(c);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pos_ff <= pos_in;
      end
   end

endmodule

// ===== rtl/core/plf_merge.sv =====
// Combines both lane positions into the ciphertext pair.
module plf_merge (
   input  logic                 clock,
   input  logic                 load,
   input  plf_pkg::square_type  square,
   input  plf_pkg::pos_type     pos_a,
   input  plf_pkg::pos_type     pos_b,
   output plf_pkg::letter_type  cipher_first_ff,
   output plf_pkg::letter_type  cipher_second_ff,
   output logic                 missing_ff
);

   plf_pkg::coord_type  row_a;
   plf_pkg::coord_type  col_a;
   plf_pkg::coord_type  row_b;
   plf_pkg::coord_type  col_b;
   logic                missing_in;
   plf_pkg::letter_type cipher_first_in;
   plf_pkg::letter_type cipher_second_in;

   always_comb begin
      priority if (pos_a.row == pos_b.row) begin
         row_a = pos_a.row;
         col_a = plf_pkg::wrap_inc(pos_a.col);
         row_b = pos_b.row;
         col_b = plf_pkg::wrap_inc(pos_b.col);
      end else if (pos_a.col == pos_b.col) begin
         row_a = plf_pkg::wrap_inc(pos_a.row);
         col_a = pos_a.col;
         row_b = plf_pkg::wrap_inc(pos_b.row);
         col_b = pos_b.col;
      end else begin
         row_a = pos_a.row;
         col_a = pos_b.col;
         row_b = pos_b.row;
         col_b = pos_a.col;
      end
      missing_in = !(pos_a.hit && pos_b.hit);
      // A letter that is not in the square forces both outputs to zero.
      cipher_first_in  = missing_in ? '0 : plf_pkg::cell_at(square, row_a, col_a);
      cipher_second_in = missing_in ? '0 : plf_pkg::cell_at(square, row_b, col_b);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cipher_first_ff  <= cipher_first_in;
         cipher_second_ff <= cipher_second_in;
         missing_ff       <= missing_in;
      end
   end

endmodule

// ===== rtl/core/playfair_digraph_encrypt.sv =====
// Channel   Direction  Words carried
// req_chan  in         first_letter, second_letter, second_present
// rsp_chan  out        cipher_first, cipher_second, letter_missing
// csr_chan  in         index (0 to 4 = square rows), data (five letters, column 0 low)
//
// One word is taken per cycle while the output is not stalled.
// Each result passes two register stages: the two search lanes, then the merge.
// Reset clears the square rows to zero and empties both stages.
// A stalled result holds the merge stage and, once the lane stage is full, the input.
module playfair_digraph_encrypt (
   input  logic      clock,
   input  logic      reset,
   plf_req_if.sink   req_chan,
   plf_rsp_if.source rsp_chan,
   plf_csr_if.sink   csr_chan
);

   plf_pkg::square_type  square_ff;
   plf_pkg::square_type  square_in;
   logic                 a_valid_ff;
   logic                 a_valid_in;
   logic                 b_valid_ff;
   logic                 b_valid_in;
   logic                 a_ready;
   logic                 b_ready;
   plf_pkg::letter_type  letter_a;
   plf_pkg::letter_type  letter_b;
   plf_pkg::pos_type     pos_a;
   plf_pkg::pos_type     pos_b;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      square_in = square_ff;
      for (int r = 0; r < plf_pkg::SqDim; r++) begin
         if (csr_chan.valid && csr_chan.index == plf_pkg::reg_index_type'(r)) begin
            square_in[r] = csr_chan.data;
         end
      end
   end

   assign b_ready = !b_valid_ff || rsp_chan.ready;
   assign a_ready = !a_valid_ff || b_ready;
   assign req_chan.ready = a_ready;

   assign a_valid_in = a_ready ? req_chan.valid : a_valid_ff;
   assign b_valid_in = b_ready ? a_valid_ff : b_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         for (int r = 0; r < plf_pkg::SqDim; r++) begin
            square_ff[r] <= '0;
         end
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         square_ff  <= square_in;
      end
   end

   assign letter_a = plf_pkg::fold(req_chan.first_letter);
   assign letter_b = req_chan.second_present ? plf_pkg::fold(req_chan.second_letter)
                                             : plf_pkg::CodeX;

   plf_locate u_lane_a (
      .clock  (clock),
      .load   (a_ready),
      .square (square_ff),
      .letter (letter_a),
      .pos_ff (pos_a)
   );

   plf_locate u_lane_b (
      .clock  (clock),
      .load   (a_ready),
      .square (square_ff),
      .letter (letter_b),
      .pos_ff (pos_b)
   );

   plf_merge u_merge (
      .clock            (clock),
      .load             (b_ready),
      .square           (square_ff),
      .pos_a            (pos_a),
      .pos_b            (pos_b),
      .cipher_first_ff  (rsp_chan.cipher_first),
      .cipher_second_ff (rsp_chan.cipher_second),
      .missing_ff       (rsp_chan.letter_missing)
   );

   assign rsp_chan.valid = b_valid_ff;

   a_missing_zero: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && rsp_chan.letter_missing) |->
         (rsp_chan.cipher_first == '0 && rsp_chan.cipher_second == '0))
      else $error("missing letter must give zero cipher letters");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> a_valid_ff)
      else $error("accepted word did not reach the lane stage");

   a_lane_holds: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && !b_ready) |=> (a_valid_ff && $stable(pos_a) && $stable(pos_b)))
      else $error("lane stage lost a word while stalled");

   a_lane_moves: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && b_ready) |=> b_valid_ff)
      else $error("lane stage word did not reach the merge stage");

endmodule
